[src/gjyd_pkg.sv]
// ----------------------------------------------------------------------------
// gjyd_pkg
// Shared widths, status codes, constants and month tables for the
// Gregorian to Julian year / day-of-year converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gjyd_pkg;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DOY_W    = 9;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_YEAR  = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_BAD_DAY   = 2'd3
  } status_t;

  // Two-digit year defaults
  localparam logic signed [YEAR_W-1:0] CENT21_LAST = 16'sd49;
  localparam logic signed [YEAR_W-1:0] CENT20_LAST = 16'sd99;
  localparam logic signed [YEAR_W-1:0] CENT21_ADD  = 16'sd2000;
  localparam logic signed [YEAR_W-1:0] CENT20_ADD  = 16'sd1900;
  localparam logic signed [YEAR_W-1:0] YEAR_MIN    = -16'sd4711;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

  // Shift that makes every valid year positive; a multiple of 400 so the
  // leap rule is unchanged.
  localparam int EPOCH_SHIFT = 4800;

  // Divide a 16-bit value by 100: multiply by ceil(2^S/100) and shift.
  localparam int CENTURY      = 100;
  localparam int DIV100_SHIFT = 23;
  localparam logic [16:0] DIV100_MULT =
    17'((2 ** DIV100_SHIFT + CENTURY - 1) / CENTURY);

  localparam int DAYS_Y  = 365;
  localparam int DAYS_4Y = 1461;

  // Day number minus one splits into 1461*(b/4) plus a small term. The
  // small term is lifted by Q_BIAS spans of four years to stay positive.
  localparam int Q_BIAS   = 22;
  localparam int DAY_BASE = 30661;
  localparam int WP_BIAS  = Q_BIAS * DAYS_4Y - DAY_BASE;
  localparam int JY_BIAS  = 4716 + 4 * Q_BIAS;

  // e is set once 80*(rr+30)/2447 reaches 11
  localparam int E_MIN_X = (11 * 2447 + 79) / 80;
  localparam int E_MIN_R = E_MIN_X - 30;
  localparam int DOY_BASE = 59;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // 367*(m-2+12a)/12, with March as the first month of the count
  function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
    logic [8:0] mt;
    case (m)
      4'd1:    mt = 9'd336;
      4'd2:    mt = 9'd367;
      4'd3:    mt = 9'd30;
      4'd4:    mt = 9'd61;
      4'd5:    mt = 9'd91;
      4'd6:    mt = 9'd122;
      4'd7:    mt = 9'd152;
      4'd8:    mt = 9'd183;
      4'd9:    mt = 9'd214;
      4'd10:   mt = 9'd244;
      4'd11:   mt = 9'd275;
      4'd12:   mt = 9'd305;
      default: mt = 9'd0;
    endcase
    return mt;
  endfunction

  // floor(1461*j/4) for the year within a four-year cycle
  function automatic logic [10:0] quarter_offset(input logic [1:0] j);
    logic [10:0] off;
    case (j)
      2'd0:    off = 11'd0;
      2'd1:    off = 11'd365;
      2'd2:    off = 11'd730;
      2'd3:    off = 11'd1095;
      default: off = 11'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

[src/gregorian_to_julian_year_day.sv]
// ----------------------------------------------------------------------------
// gregorian_to_julian_year_day
// Gregorian year/month/day to year and day-in-year of a Julian calendar
// aligned to the 20th/21st century, with a validity status.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | greg_year[15:0] greg_month[19:16] greg_day[24:20] | -
//  m_      | out | julian_year[15:0] day_of_year[24:16]        | status[1:0]
//
//  Six register stages; one word can enter every cycle while the output
//  is not stalled. The two divide-by-100 multipliers in stage two set the
//  longest path. Reset (rst, synchronous) empties all stages.
//  A stalled output holds its word; each stage takes a new word whenever
//  it is empty or the stage after it moves, so bubbles close up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gregorian_to_julian_year_day
  import gjyd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [S_TDATA_W-1:0]  s_tdata,   // greg_year, greg_month, greg_day
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // julian_year, day_of_year
  output logic [STATUS_W-1:0]  m_tuser    // status
);

  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   adv;
  logic [NSTAGE-1:0] vld_in;

  always_comb begin
    adv[NSTAGE] = m_tready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign vld_in   = {vld[NSTAGE-2:0], s_tvalid};
  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [YEAR_W-1:0] y_in;
  logic signed [YEAR_W-1:0] y_adj;
  logic [MONTH_W-1:0]       mon_in;
  logic [DAY_W-1:0]         day_in;
  logic                     jan_feb;
  logic [16:0]              yp_wide;

  assign y_in    = $signed(s_tdata[15:0]);
  assign mon_in  = s_tdata[19:16];
  assign day_in  = s_tdata[24:20];
  assign jan_feb = (mon_in == MONTH_JAN) || (mon_in == MONTH_FEB);

  always_comb begin
    y_adj = y_in;
    if (!y_in[YEAR_W-1] && (y_in <= CENT21_LAST)) begin
      y_adj = y_in + CENT21_ADD;
    end else if (!y_in[YEAR_W-1] && (y_in <= CENT20_LAST)) begin
      y_adj = y_in + CENT20_ADD;
    end
  end

  assign yp_wide = {y_adj[YEAR_W-1], y_adj} + 17'(EPOCH_SHIFT);

  logic                 s1_bad_year, s1_bad_month, s1_feb;
  logic [15:0]          s1_yp, s1_bp;
  logic [8:0]           s1_mterm;
  logic [DAY_W-1:0]     s1_mlen, s1_day;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_bad_year  <= y_adj < YEAR_MIN;
      s1_bad_month <= (mon_in == 4'd0) || (mon_in > MONTH_DEC);
      s1_feb       <= mon_in == MONTH_FEB;
      s1_yp        <= yp_wide[15:0];
      s1_bp        <= yp_wide[15:0] - {15'd0, jan_feb};
      s1_mterm     <= month_term(mon_in);
      s1_mlen      <= month_len(mon_in);
      s1_day       <= day_in;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [32:0] py, pb;

  assign py = 33'(s1_yp) * 33'(DIV100_MULT);
  assign pb = 33'(s1_bp) * 33'(DIV100_MULT);

  logic             s2_bad_year, s2_bad_month, s2_feb;
  logic [15:0]      s2_yp;
  logic [8:0]       s2_qy, s2_qb, s2_mterm;
  logic [13:0]      s2_k;
  logic [1:0]       s2_j;
  logic [DAY_W-1:0] s2_mlen, s2_day;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_bad_year  <= s1_bad_year;
      s2_bad_month <= s1_bad_month;
      s2_feb       <= s1_feb;
      s2_yp        <= s1_yp;
      s2_qy        <= py[DIV100_SHIFT +: 9];
      s2_qb        <= pb[DIV100_SHIFT +: 9];
      s2_k         <= s1_bp[15:2];
      s2_j         <= s1_bp[1:0];
      s2_mterm     <= s1_mterm;
      s2_mlen      <= s1_mlen;
      s2_day       <= s1_day;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [15:0]      yp_x100;
  logic             leap;
  logic [DAY_W-1:0] mlen_eff;
  status_t          stat2;
  logic [10:0]      c3;
  logic [11:0]      wp;

  assign yp_x100  = 16'(16'(s2_qy) * 16'(CENTURY));
  assign leap     = (s2_yp[1:0] == 2'd0) && ((s2_yp != yp_x100) || (s2_qy[1:0] == 2'd0));
  assign mlen_eff = (s2_feb && leap) ? FEB_LEAP_LEN : s2_mlen;
  // 3*((b+4900)/100), with (b+4900)/100 = (b+4800)/100 + 1
  assign c3       = (11'(s2_qb) + 11'd1) * 11'd3;
  assign wp       = 12'(quarter_offset(s2_j)) + 12'(s2_mterm) + 12'(s2_day)
                  + 12'(WP_BIAS) - 12'(c3[10:2]);

  always_comb begin
    if (s2_bad_year) begin
      stat2 = ST_BAD_YEAR;
    end else if (s2_bad_month) begin
      stat2 = ST_BAD_MONTH;
    end else if ((s2_day == '0) || (s2_day > mlen_eff)) begin
      stat2 = ST_BAD_DAY;
    end else begin
      stat2 = ST_OK;
    end
  end

  logic [11:0] s3_wp;
  logic [13:0] s3_k;
  status_t     s3_stat;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_wp   <= wp;
      s3_k    <= s2_k;
      s3_stat <= stat2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [1:0]  qw;
  logic [11:0] r_wide;

  always_comb begin
    if (s3_wp >= 12'(2 * DAYS_4Y)) begin
      qw = 2'd2;
    end else if (s3_wp >= 12'(DAYS_4Y)) begin
      qw = 2'd1;
    end else begin
      qw = 2'd0;
    end
  end

  assign r_wide = s3_wp - 12'(12'(qw) * 12'(DAYS_4Y)) + 12'd1;

  logic [10:0] s4_r;
  logic [14:0] s4_q;
  status_t     s4_stat;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_r    <= r_wide[10:0];
      s4_q    <= 15'(s3_k) + 15'(qw);
      s4_stat <= s3_stat;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [1:0]  n;
  logic [10:0] rr_wide;

  // n = (r-1)/365 - r/1461: whole years into the four-year cycle, 0..3
  always_comb begin
    if (s4_r > 11'(3 * DAYS_Y)) begin
      n = 2'd3;
    end else if (s4_r > 11'(2 * DAYS_Y)) begin
      n = 2'd2;
    end else if (s4_r > 11'(DAYS_Y)) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
  end

  assign rr_wide = s4_r - 11'(11'(n) * 11'(DAYS_Y));

  logic [8:0]  s5_rr;
  logic [1:0]  s5_n;
  logic        s5_e;
  logic [14:0] s5_q;
  status_t     s5_stat;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_rr   <= rr_wide[8:0];
      s5_n    <= n;
      s5_e    <= rr_wide >= 11'(E_MIN_R);
      s5_q    <= s4_q;
      s5_stat <= s4_stat;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [10:0] doy_wide;
  logic [16:0] jy_wide;
  logic        no_result;

  assign doy_wide  = 11'(DOY_BASE) + 11'(s5_rr) + 11'((s5_n == 2'd0) && !s5_e)
                   - (s5_e ? 11'(DAYS_Y) : 11'd0);
  assign jy_wide   = {s5_q, 2'b00} + 17'(s5_n) + 17'(s5_e) - 17'(JY_BIAS);
  assign no_result = (s5_stat == ST_BAD_YEAR) || (s5_stat == ST_BAD_MONTH);

  logic [YEAR_W-1:0] o_jy;
  logic [DOY_W-1:0]  o_doy;
  status_t           o_stat;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      o_jy   <= no_result ? '0 : jy_wide[YEAR_W-1:0];
      o_doy  <= no_result ? '0 : doy_wide[DOY_W-1:0];
      o_stat <= s5_stat;
    end
  end

  assign m_tvalid = vld[NSTAGE-1];
  assign m_tdata  = {(M_TDATA_W - YEAR_W - DOY_W)'(0), o_doy, o_jy};
  assign m_tuser  = o_stat;

endmodule

`default_nettype wire

[src/gjyd_checker.sv]
// ----------------------------------------------------------------------------
// gjyd_checker
// Port-level checks for the Gregorian to Julian converter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gjyd_checker
  import gjyd_pkg::*;
(
  input wire                 clk,
  input wire                 rst,
  input wire                 m_tvalid,
  input wire                 m_tready,
  input wire [M_TDATA_W-1:0] m_tdata,
  input wire [STATUS_W-1:0]  m_tuser
);

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // bad year or month give zero fields
  a_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_BAD_YEAR) || (m_tuser == ST_BAD_MONTH))
    |-> (m_tdata[YEAR_W+DOY_W-1:0] == '0))
    else $error("nonzero fields on rejected date");

  // a good date lands on a real day of the year
  a_doy_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_OK)
    |-> (m_tdata[YEAR_W +: DOY_W] >= 9'd1) && (m_tdata[YEAR_W +: DOY_W] <= 9'd366))
    else $error("day of year out of range");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:YEAR_W+DOY_W] == '0))
    else $error("padding bits set");

endmodule

bind gregorian_to_julian_year_day gjyd_checker u_gjyd_checker (.*);

`default_nettype wire

[sim/gregorian_to_julian_year_day_tb.sv]
// ----------------------------------------------------------------------------
// gregorian_to_julian_year_day_tb
// Streams Gregorian dates into the converter and checks every output word
// against a day-number predictor: first a directed set of edge dates, then
// random dates in four traffic phases (free flow, sparse input, heavy
// output backpressure, both together).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gregorian_to_julian_year_day_tb
  import gjyd_pkg::*;
();

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 4;
  localparam int PIPE_DEPTH    = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_DATES   = 300;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    status_t           status;
  } jdate_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;     // greg_year, greg_month, greg_day
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // julian_year, day_of_year
  logic [STATUS_W-1:0]  m_tuser;          // status

  logic [S_TDATA_W-1:0] dates_to_send [$];
  jdate_t               expected_dates [$];
  bit                   word_taken = 1'b0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   errors = 0;
  int                   quiet_cycles = 0;

  gregorian_to_julian_year_day dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Gregorian date -> day number -> re-aligned Julian year and day in year.
  // Signed longint division truncates toward zero, as the algorithm needs.
  function automatic jdate_t convert_date(input logic signed [YEAR_W-1:0] yr_in,
                                          input logic [MONTH_W-1:0] mon_in,
                                          input logic [DAY_W-1:0] day_in);
    longint y, m, d, mlen, a, b, num, q, r, n, e, t, doy, jy;
    bit     leap;
    jdate_t res;
    y = yr_in;
    m = mon_in;
    d = day_in;
    res = '0;
    if (y >= 0 && y <= 49) begin
      y = y + 2000;
    end else if (y >= 50 && y <= 99) begin
      y = y + 1900;
    end
    if (y < -4711) begin
      res.status = ST_BAD_YEAR;
      return res;
    end
    if (m < 1 || m > 12) begin
      res.status = ST_BAD_MONTH;
      return res;
    end
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m == 2) begin
      mlen = leap ? 29 : 28;
    end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
      mlen = 30;
    end else begin
      mlen = 31;
    end
    res.status = (d < 1 || d > mlen) ? ST_BAD_DAY : ST_OK;

    a   = (14 - m) / 12;
    b   = y - a;
    num = (1461 * (b + 4800)) / 4 + (367 * (m - 2 + 12 * a)) / 12
        - (3 * ((b + 4900) / 100)) / 4 + d - 30660;

    q   = (num - 1) / 1461;
    r   = num - 1461 * q;
    n   = (r - 1) / 365 - r / 1461;
    e   = ((80 * (r - 365 * n + 30)) / 2447) / 11;
    t   = n + e;
    doy = 59 + (r - 365 * t + ((4 - n) / 4) * (1 - e));
    jy  = (4 * q + t) - 4716;

    res.year = jy[YEAR_W-1:0];
    res.doy  = doy[DOY_W-1:0];
    return res;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_date(input int y, input int m, input int d);
    return {7'd0, d[DAY_W-1:0], m[MONTH_W-1:0], y[YEAR_W-1:0]};
  endfunction

  task automatic queue_random_dates(input int count);
    int y, m, d, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        y = int'($urandom_range(16'hFFFF)) - 32768;          // any 16-bit year
      end else if (pick < 25) begin
        y = $urandom_range(99);                              // two-digit years
      end else if (pick < 35) begin
        y = -4700 - int'($urandom_range(20));                // around the lower limit
      end else if (pick < 50) begin
        y = 100 * int'($urandom_range(374)) - 4700 + int'($urandom_range(2)) - 1;
      end else begin
        y = int'($urandom_range(32767 + 4711)) - 4711;
      end
      m = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
      d = ($urandom_range(15) == 0) ? $urandom_range(31) : $urandom_range(31, 1);
      dates_to_send.push_back(pack_date(y, m, d));
    end
  endtask

  // hold until everything queued has gone in and come back out
  task automatic wait_drained();
    while (dates_to_send.size() != 0 || s_tvalid || expected_dates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Input side: launch the next word once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (dates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= dates_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    jdate_t want;
    word_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(convert_date(s_tdata[15:0], s_tdata[19:16], s_tdata[24:20]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected output word tdata=%h tuser=%0d", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (m_tdata[15:0] !== want.year) begin
            $display("%0t: julian_year expected %0d actual %0d", $time,
                     $signed(want.year), $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[24:16] !== want.doy) begin
            $display("%0t: day_of_year expected %0d actual %0d", $time,
                     want.doy, m_tdata[24:16]);
            errors++;
          end
          if (m_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("gregorian_to_julian_year_day_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Edge dates: year limits, century defaults, leap rules, bad fields.
    dates_to_send.push_back(pack_date(-32768, 1, 1));
    dates_to_send.push_back(pack_date(32767, 12, 31));
    dates_to_send.push_back(pack_date(-4711, 1, 1));
    dates_to_send.push_back(pack_date(-4712, 6, 15));
    dates_to_send.push_back(pack_date(-4712, 0, 15));     // bad year wins over bad month
    dates_to_send.push_back(pack_date(0, 2, 29));         // 2000, leap
    dates_to_send.push_back(pack_date(49, 12, 31));
    dates_to_send.push_back(pack_date(50, 1, 1));
    dates_to_send.push_back(pack_date(99, 3, 1));
    dates_to_send.push_back(pack_date(100, 2, 29));       // not leap, not defaulted
    dates_to_send.push_back(pack_date(-1, 7, 4));
    dates_to_send.push_back(pack_date(1900, 2, 29));      // century, not leap
    dates_to_send.push_back(pack_date(1900, 3, 1));
    dates_to_send.push_back(pack_date(2100, 2, 28));
    dates_to_send.push_back(pack_date(2024, 2, 29));
    dates_to_send.push_back(pack_date(2023, 2, 29));
    dates_to_send.push_back(pack_date(2023, 4, 31));
    dates_to_send.push_back(pack_date(2023, 5, 0));       // day zero spills back
    dates_to_send.push_back(pack_date(2023, 12, 31));
    dates_to_send.push_back(pack_date(2023, 13, 5));
    dates_to_send.push_back(pack_date(2023, 15, 31));
    dates_to_send.push_back(pack_date(1999, 0, 0));
    for (int mon = 1; mon <= 12; mon += 11) begin
      dates_to_send.push_back(pack_date(1582, mon, 31));
    end
    wait_drained();

    queue_random_dates(PHASE_DATES);
    wait_drained();

    send_idle_pct = 86;
    queue_random_dates(PHASE_DATES);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 86;
    queue_random_dates(PHASE_DATES);
    wait_drained();

    send_idle_pct  = 36;
    recv_stall_pct = 36;
    queue_random_dates(PHASE_DATES);
    wait_drained();

    // let any stray word surface
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("gregorian_to_julian_year_day_tb passed");
    end else begin
      $display("gregorian_to_julian_year_day_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
